>>> sv/crmf_pkg.sv
`timescale 1ns / 1ps
// crmf_pkg: shared types, constants and helpers for the can rx mailbox filter
// no dependencies; imported by every module of the block
package crmf_pkg;

  localparam int MAX_ENTRIES = 6;
  localparam int ENT_W = 3;
  localparam int ENTRY_W = 31;
  localparam int IDENT_W = 29;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W = 3;

  localparam logic [ENTRY_W-1:0] ENTRY_RESET = 31'h4000_0000;
  localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

  localparam int WORD_TX_BIT = 30;
  localparam int WORD_EXT_BIT = 29;
  localparam int IDE_BIT = 19;
  localparam logic [3:0] LEN_MAX = 4'd8;

  localparam logic [REG_IDX_W-1:0] REG_TIMEOUT = 3'd6;

  localparam logic [1:0] OP_FRAME = 2'd0;
  localparam logic [1:0] OP_SWEEP = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [31:0] raw_ident;
    logic [3:0] frame_length;
    logic [63:0] frame_payload;
    logic [31:0] now_time;
    logic [2:0] entry_select;
    logic clear_flags;
  } item_t;

  typedef struct packed {
    logic [5:0] match_mask;
    logic [IDENT_W-1:0] decoded_ident;
    logic ident_extended;
    logic [5:0] new_flags;
    logic [5:0] overrun_flags;
    logic [5:0] timeout_flags;
    logic [63:0] read_payload;
    logic [3:0] read_length;
    logic [31:0] read_stamp;
  } result_t;

  typedef logic [MAX_ENTRIES-1:0][ENTRY_W-1:0] entry_words_t;

  // byte enables for a stored length of at most eight
  function automatic logic [63:0] byte_mask(input logic [3:0] len);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < len) begin
        m[8*b +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

>>> sv/can_rx_mailbox_filter.sv
`timescale 1ns / 1ps
// can_rx_mailbox_filter: can receive filter with mailboxes, top level
// flow: an accepted beat goes through ST_WALK, ST_DONE and the output register; frame and sweep
// beats walk every table entry, read and unused-op beats visit no entry; one beat in flight, the next
// is accepted only back in ST_IDLE; the single entry unit visits one table entry per cycle
// reset: synchronous active low; flags, mailboxes cleared, config regs to defaults
module can_rx_mailbox_filter
  import crmf_pkg::*;
#(
  parameter int TABLE_ENTRIES = MAX_ENTRIES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  item_t                 in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output result_t               out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  item_t item_r, item_nxt;
  logic [IDENT_W-1:0] ident_r, ident_nxt;
  logic ext_r, ext_nxt;
  logic [3:0] len_r, len_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [TABLE_ENTRIES-1:0] match_r, match_nxt;
  logic [TABLE_ENTRIES-1:0] fresh_r, fresh_nxt;
  logic [TABLE_ENTRIES-1:0] ovr_r, ovr_nxt;
  logic [TABLE_ENTRIES-1:0] stale_r, stale_nxt;
  logic [63:0] rd_pay_r, rd_pay_nxt;
  logic [3:0] rd_len_r, rd_len_nxt;
  logic [31:0] rd_stamp_r, rd_stamp_nxt;
  logic out_valid_r, out_valid_nxt;
  result_t out_r, out_nxt;

  entry_words_t entry_words;
  logic [31:0] timeout_ticks;
  logic in_accept;
  logic sel_ok;
  logic [IDX_W-1:0] sel_idx;
  logic [IDX_W-1:0] mb_addr;
  logic mb_wr;
  logic [63:0] mb_rd_payload;
  logic [3:0] mb_rd_length;
  logic [31:0] mb_rd_stamp;
  logic unit_hit, unit_late;
  logic in_ext;
  logic [IDENT_W-1:0] in_ident;
  result_t result;

  crmf_cfg_regs u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .entry_words  (entry_words),
    .timeout_ticks(timeout_ticks)
  );

  crmf_entry_unit u_unit (
    .entry_word   (entry_words[ENT_W'(idx_r)]),
    .ident        (ident_r),
    .ext          (ext_r),
    .stamp        (mb_rd_stamp),
    .timeout_ticks(timeout_ticks),
    .now_time     (item_r.now_time),
    .hit          (unit_hit),
    .late         (unit_late)
  );

  crmf_mailbox #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .IDX_W        (IDX_W)
  ) u_mailbox (
    .clk       (clk),
    .rst_n     (rst_n),
    .addr      (mb_addr),
    .wr_en     (mb_wr),
    .wr_payload(item_r.frame_payload),
    .wr_mask   (byte_mask(len_r)),
    .wr_length (len_r),
    .wr_stamp  (item_r.now_time),
    .rd_payload(mb_rd_payload),
    .rd_length (mb_rd_length),
    .rd_stamp  (mb_rd_stamp)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  assign sel_ok = item_r.entry_select < ENT_W'(TABLE_ENTRIES);
  assign sel_idx = item_r.entry_select[IDX_W-1:0];
  assign mb_addr = (item_r.op == OP_READ) ? sel_idx : idx_r;
  assign mb_wr = (state_r == ST_WALK) && (item_r.op == OP_FRAME) && unit_hit;

  // identifier decode from the idr image
  assign in_ext = in_data.raw_ident[IDE_BIT];
  assign in_ident = in_ext ? {in_data.raw_ident[31:21], in_data.raw_ident[18:1]}
                           : IDENT_W'(in_data.raw_ident[31:21]);

  always_comb begin
    result = '0;
    if (item_r.op == OP_FRAME) begin
      result.decoded_ident = ident_r;
      result.ident_extended = ext_r;
    end
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      result.match_mask[i] = match_r[i];
      result.new_flags[i] = fresh_r[i];
      result.overrun_flags[i] = ovr_r[i];
      result.timeout_flags[i] = stale_r[i];
    end
    result.read_payload = rd_pay_r;
    result.read_length = rd_len_r;
    result.read_stamp = rd_stamp_r;
  end

  always_comb begin
    state_nxt = state_r;
    item_nxt = item_r;
    ident_nxt = ident_r;
    ext_nxt = ext_r;
    len_nxt = len_r;
    idx_nxt = idx_r;
    match_nxt = match_r;
    fresh_nxt = fresh_r;
    ovr_nxt = ovr_r;
    stale_nxt = stale_r;
    rd_pay_nxt = rd_pay_r;
    rd_len_nxt = rd_len_r;
    rd_stamp_nxt = rd_stamp_r;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          item_nxt = in_data;
          ident_nxt = in_ident;
          ext_nxt = in_ext;
          len_nxt = (in_data.frame_length > LEN_MAX) ? LEN_MAX : in_data.frame_length;
          idx_nxt = '0;
          match_nxt = '0;
          rd_pay_nxt = '0;
          rd_len_nxt = '0;
          rd_stamp_nxt = '0;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        case (item_r.op)
          OP_FRAME: begin
            if (unit_hit) begin
              match_nxt[idx_r] = 1'b1;
              if (fresh_r[idx_r]) begin
                ovr_nxt[idx_r] = 1'b1;
              end else begin
                fresh_nxt[idx_r] = 1'b1;
              end
            end
            idx_nxt = idx_r + 1'b1;
            if (idx_r == LAST_IDX) begin
              state_nxt = ST_DONE;
            end
          end
          OP_SWEEP: begin
            stale_nxt[idx_r] = unit_late;
            idx_nxt = idx_r + 1'b1;
            if (idx_r == LAST_IDX) begin
              state_nxt = ST_DONE;
            end
          end
          OP_READ: begin
            if (sel_ok) begin
              rd_pay_nxt = mb_rd_payload;
              rd_len_nxt = mb_rd_length;
              rd_stamp_nxt = mb_rd_stamp;
              if (item_r.clear_flags) begin
                fresh_nxt[sel_idx] = 1'b0;
                ovr_nxt[sel_idx] = 1'b0;
              end
            end
            state_nxt = ST_DONE;
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt = result;
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      fresh_r <= '0;
      ovr_r <= '0;
      stale_r <= '0;
      idx_r <= '0;
      match_r <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      fresh_r <= fresh_nxt;
      ovr_r <= ovr_nxt;
      stale_r <= stale_nxt;
      idx_r <= idx_nxt;
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    ident_r <= ident_nxt;
    ext_r <= ext_nxt;
    len_r <= len_nxt;
    rd_pay_r <= rd_pay_nxt;
    rd_len_r <= rd_len_nxt;
    rd_stamp_r <= rd_stamp_nxt;
    out_r <= out_nxt;
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register not one-hot");

  a_accept_walk: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r == ST_WALK)
    else $error("accepted beat did not start the entry walk");

  a_overrun_needs_new: assert property (@(posedge clk) disable iff (!rst_n)
    (ovr_r & ~fresh_r) == '0)
    else $error("overrun flag set without new flag");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> idx_r <= LAST_IDX)
    else $error("entry index past table end");

  a_match_frame_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && (item_r.op != OP_FRAME) |-> match_r == '0)
    else $error("match mask set on a non-frame beat");

endmodule

>>> sv/crmf_cfg_regs.sv
`timescale 1ns / 1ps
// crmf_cfg_regs: apb register file with the six filter entry words and the timeout
// depends on crmf_pkg
module crmf_cfg_regs
  import crmf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output entry_words_t          entry_words,
  output logic [31:0]           timeout_ticks
);

  entry_words_t entry_words_r;
  logic [31:0] timeout_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic wr_en;

  assign pready = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        entry_words_r[i] <= ENTRY_RESET;
      end
      timeout_r <= TIMEOUT_RESET;
    end else if (wr_en) begin
      if (reg_idx < REG_IDX_W'(MAX_ENTRIES)) begin
        entry_words_r[reg_idx] <= pwdata[ENTRY_W-1:0];
      end else if (reg_idx == REG_TIMEOUT) begin
        timeout_r <= pwdata;
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx < REG_IDX_W'(MAX_ENTRIES)) begin
      prdata = {1'b0, entry_words_r[reg_idx]};
    end else if (reg_idx == REG_TIMEOUT) begin
      prdata = timeout_r;
    end
  end

  assign entry_words = entry_words_r;
  assign timeout_ticks = timeout_r;

endmodule

>>> sv/crmf_entry_unit.sv
`timescale 1ns / 1ps
// crmf_entry_unit: shared per-entry unit, identifier compare and stamp timeout check
// depends on crmf_pkg
module crmf_entry_unit
  import crmf_pkg::*;
(
  input  logic [ENTRY_W-1:0] entry_word,
  input  logic [IDENT_W-1:0] ident,
  input  logic               ext,
  input  logic [31:0]        stamp,
  input  logic [31:0]        timeout_ticks,
  input  logic [31:0]        now_time,
  output logic               hit,
  output logic               late
);

  logic [31:0] limit;

  assign hit = !entry_word[WORD_TX_BIT] && (entry_word[WORD_EXT_BIT] == ext) &&
               (entry_word[IDENT_W-1:0] == ident);

  // 32-bit wrap on the limit
  assign limit = stamp + timeout_ticks;
  assign late = now_time > limit;

endmodule

>>> sv/crmf_mailbox.sv
`timescale 1ns / 1ps
// crmf_mailbox: per-entry payload, length and stamp store with byte-masked update
// depends on crmf_pkg
module crmf_mailbox
  import crmf_pkg::*;
#(
  parameter int TABLE_ENTRIES = MAX_ENTRIES,
  parameter int IDX_W = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] addr,
  input  logic             wr_en,
  input  logic [63:0]      wr_payload,
  input  logic [63:0]      wr_mask,
  input  logic [3:0]       wr_length,
  input  logic [31:0]      wr_stamp,
  output logic [63:0]      rd_payload,
  output logic [3:0]       rd_length,
  output logic [31:0]      rd_stamp
);

  logic [63:0] payload_r [TABLE_ENTRIES];
  logic [3:0] length_r [TABLE_ENTRIES];
  logic [31:0] stamp_r [TABLE_ENTRIES];

  assign rd_payload = payload_r[addr];
  assign rd_length = length_r[addr];
  assign rd_stamp = stamp_r[addr];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        payload_r[i] <= '0;
        length_r[i] <= '0;
        stamp_r[i] <= '0;
      end
    end else if (wr_en) begin
      // bytes past the new length keep their old contents
      payload_r[addr] <= (payload_r[addr] & ~wr_mask) | (wr_payload & wr_mask);
      length_r[addr] <= wr_length;
      stamp_r[addr] <= wr_stamp;
    end
  end

endmodule
